// ===== hdl/pftw_pkg.sv =====
package pftw_pkg;

    localparam int DIM_BITS = 8;
    localparam int VOL_BITS = 30;
    localparam logic [VOL_BITS-1:0] VOL_MAX = {VOL_BITS{1'b1}};

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // sequencer states
    localparam int ST_BITS = 4;
    localparam logic [ST_BITS-1:0] ST_IDLE     = 4'd0;
    localparam logic [ST_BITS-1:0] ST_SEED     = 4'd1;
    localparam logic [ST_BITS-1:0] ST_SEED_RD  = 4'd2;
    localparam logic [ST_BITS-1:0] ST_PU       = 4'd3;
    localparam logic [ST_BITS-1:0] ST_PU_CMP   = 4'd4;
    localparam logic [ST_BITS-1:0] ST_POP      = 4'd5;
    localparam logic [ST_BITS-1:0] ST_POP_TOP  = 4'd6;
    localparam logic [ST_BITS-1:0] ST_POP_LAST = 4'd7;
    localparam logic [ST_BITS-1:0] ST_SD       = 4'd8;
    localparam logic [ST_BITS-1:0] ST_SD_L     = 4'd9;
    localparam logic [ST_BITS-1:0] ST_SD_R     = 4'd10;
    localparam logic [ST_BITS-1:0] ST_SD_CMP   = 4'd11;
    localparam logic [ST_BITS-1:0] ST_NB       = 4'd12;
    localparam logic [ST_BITS-1:0] ST_NB_ADDR  = 4'd13;
    localparam logic [ST_BITS-1:0] ST_NB_CHK   = 4'd14;

endpackage

// ===== hdl/priority_flood_trapped_water.sv =====
// Trapped-water volume of an elevation grid by priority flood.
// Input channel: one cell height per word, raster order, accepted on a clock
// edge with i_start high and o_busy low. Config channel: i_cfg_valid with
// o_cfg_ready (always high), i_cfg_index selects rows (0) or cols (1); write
// only while o_busy is low. The word that completes a grid starts the fill;
// o_busy stays high until o_valid pulses for one cycle with o_water_volume,
// then the next grid can load.
// Fill: seeding scans every cell and reads and pushes each border cell, then
// per cell one pop (with a sift down), four neighbor checks (a side outside
// the grid is skipped without a read), a step to close the scan, and a push
// (with a sift up); the heap memory has a single read port.
// Reset returns the block to idle with rows = cols = 128 and an empty load.
// The receiver cannot stall: the result is shown for exactly one cycle.
// Visited flags are cleared as each cell is loaded, so no clearing pass.
module priority_flood_trapped_water #(
    parameter int MAX_ROWS    = 128,
    parameter int MAX_COLS    = 128,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [HEIGHT_BITS-1:0]            i_cell_height,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [pftw_pkg::DIM_BITS-1:0]     i_cfg_data,
    output logic                              o_valid,
    output logic [pftw_pkg::VOL_BITS-1:0]     o_water_volume
);

    localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
    localparam int RB  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CB  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PB  = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
    localparam int RDW = $clog2(MAX_ROWS + 1);
    localparam int CDW = $clog2(MAX_COLS + 1);
    localparam int TW  = $clog2(CELL_CAP + 1);
    localparam int HB  = HEIGHT_BITS;
    localparam int VB  = pftw_pkg::VOL_BITS;
    localparam int SW  = ((VB > HB) ? VB : HB) + 1;

    typedef struct packed {
        logic [HB-1:0] lvl;
        logic [RB-1:0] row;
        logic [CB-1:0] col;
    } t_ent;

    logic [pftw_pkg::ST_BITS-1:0] r_state, n_state, r_ret, n_ret;
    logic [pftw_pkg::DIM_BITS-1:0] r_cfg_rows, r_cfg_cols;
    logic [RDW-1:0] r_rows, n_rows, rows_c;
    logic [CDW-1:0] r_cols, n_cols, cols_c;
    logic [TW-1:0]  r_load, n_load, r_count, n_count, tot_c, idx_c;
    logic [PB-1:0]  r_i, n_i, r_m, n_m, r_spos, n_spos, r_npos, n_npos, nb_pos;
    logic [RB-1:0]  r_sr, n_sr, r_nrow, n_nrow;
    logic [CB-1:0]  r_sc, n_sc, r_ncol, n_ncol;
    logic           r_sdone, n_sdone, r_valid, n_valid;
    logic [2:0]     r_k, n_k;
    logic [VB-1:0]  r_vol, n_vol;
    t_ent           r_item, n_item, r_child, n_child, r_cur, n_cur;
    logic [PB+1:0]  lc;
    logic [SW-1:0]  vsum;

    // memories
    t_ent          heap_mem [CELL_CAP];
    logic [HB-1:0] h_mem [CELL_CAP];
    logic          v_mem [CELL_CAP];
    t_ent          r_heap_q;
    logic [HB-1:0] r_h_q;
    logic          r_v_q;

    logic          hp_we, h_we, v_we, v_wd;
    logic [PB-1:0] hp_wa, hp_ra, c_ra, h_wa, v_wa;
    t_ent          hp_wd;

    always_ff @(posedge i_clk) begin
        if (hp_we) begin
            heap_mem[hp_wa] <= hp_wd;
        end
        r_heap_q <= heap_mem[hp_ra];
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            h_mem[h_wa] <= i_cell_height;
        end
        if (v_we) begin
            v_mem[v_wa] <= v_wd;
        end
        r_h_q <= h_mem[c_ra];
        r_v_q <= v_mem[c_ra];
    end

    always_comb begin
        if (r_cfg_rows == '0) begin
            rows_c = RDW'(1);
        end else if (int'(r_cfg_rows) > MAX_ROWS) begin
            rows_c = RDW'(MAX_ROWS);
        end else begin
            rows_c = RDW'(r_cfg_rows);
        end
        if (r_cfg_cols == '0) begin
            cols_c = CDW'(1);
        end else if (int'(r_cfg_cols) > MAX_COLS) begin
            cols_c = CDW'(MAX_COLS);
        end else begin
            cols_c = CDW'(r_cfg_cols);
        end
    end

    assign tot_c  = TW'(rows_c * cols_c);
    assign idx_c  = (r_load >= tot_c) ? '0 : r_load;
    assign nb_pos = PB'(r_nrow * r_cols + TW'(r_ncol));
    assign lc     = {1'b0, r_i, 1'b1};
    assign vsum   = SW'(r_vol) + SW'(r_cur.lvl - r_h_q);

    assign o_busy         = (r_state != pftw_pkg::ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_valid;
    assign o_water_volume = r_vol;

    always_comb begin
        n_state = r_state;  n_ret = r_ret;
        n_rows = r_rows;    n_cols = r_cols;
        n_load = r_load;    n_count = r_count;
        n_i = r_i;          n_m = r_m;
        n_spos = r_spos;    n_sr = r_sr;    n_sc = r_sc;   n_sdone = r_sdone;
        n_npos = r_npos;    n_nrow = r_nrow; n_ncol = r_ncol;
        n_k = r_k;          n_vol = r_vol;  n_valid = 1'b0;
        n_item = r_item;    n_child = r_child; n_cur = r_cur;
        hp_we = 1'b0; hp_wa = r_i; hp_wd = r_item; hp_ra = '0;
        c_ra = r_spos; h_we = 1'b0; h_wa = PB'(idx_c);
        v_we = 1'b0; v_wa = r_spos; v_wd = 1'b0;

        unique case (r_state)
            pftw_pkg::ST_IDLE: begin
                if (i_start) begin
                    h_we = 1'b1;
                    v_we = 1'b1;
                    v_wa = PB'(idx_c);
                    v_wd = 1'b0;
                    n_load = idx_c + TW'(1);
                    if (idx_c + TW'(1) == tot_c) begin
                        n_load  = '0;
                        n_rows  = rows_c;
                        n_cols  = cols_c;
                        n_sr    = '0;
                        n_sc    = '0;
                        n_spos  = '0;
                        n_sdone = 1'b0;
                        n_count = '0;
                        n_vol   = '0;
                        n_state = pftw_pkg::ST_SEED;
                    end
                end
            end
            pftw_pkg::ST_SEED, pftw_pkg::ST_SEED_RD: begin
                if (r_state == pftw_pkg::ST_SEED && r_sdone) begin
                    n_state = pftw_pkg::ST_POP;
                end else if (r_state == pftw_pkg::ST_SEED &&
                             !(r_sr == '0 || RDW'(r_sr) == r_rows - RDW'(1) ||
                               r_sc == '0 || CDW'(r_sc) == r_cols - CDW'(1))) begin
                    // interior cell: skip
                    n_state = pftw_pkg::ST_SEED;
                end else if (r_state == pftw_pkg::ST_SEED) begin
                    c_ra    = r_spos;
                    n_state = pftw_pkg::ST_SEED_RD;
                end else begin
                    v_we    = 1'b1;
                    v_wa    = r_spos;
                    v_wd    = 1'b1;
                    n_item  = '{lvl: r_h_q, row: r_sr, col: r_sc};
                    n_i     = PB'(r_count);
                    n_count = r_count + TW'(1);
                    n_ret   = pftw_pkg::ST_SEED;
                    n_state = pftw_pkg::ST_PU;
                end
                // advance the raster scan unless it is done or waiting on a read
                if (!(r_state == pftw_pkg::ST_SEED && r_sdone) &&
                    n_state != pftw_pkg::ST_SEED_RD) begin
                    n_spos = r_spos + PB'(1);
                    if (CDW'(r_sc) == r_cols - CDW'(1)) begin
                        n_sc = '0;
                        n_sr = r_sr + RB'(1);
                        if (RDW'(r_sr) == r_rows - RDW'(1)) begin
                            n_sdone = 1'b1;
                        end
                    end else begin
                        n_sc = r_sc + CB'(1);
                    end
                end
            end
            pftw_pkg::ST_PU: begin
                if (r_i == '0) begin
                    hp_we   = 1'b1;
                    hp_wa   = '0;
                    hp_wd   = r_item;
                    n_state = r_ret;
                end else begin
                    hp_ra   = (r_i - PB'(1)) >> 1;
                    n_m     = (r_i - PB'(1)) >> 1;
                    n_state = pftw_pkg::ST_PU_CMP;
                end
            end
            pftw_pkg::ST_PU_CMP: begin
                hp_we = 1'b1;
                hp_wa = r_i;
                if (r_heap_q.lvl <= r_item.lvl) begin
                    hp_wd   = r_item;
                    n_state = r_ret;
                end else begin
                    hp_wd   = r_heap_q;
                    n_i     = r_m;
                    n_state = pftw_pkg::ST_PU;
                end
            end
            pftw_pkg::ST_POP: begin
                if (r_count == '0) begin
                    n_valid = 1'b1;
                    n_state = pftw_pkg::ST_IDLE;
                end else begin
                    hp_ra   = '0;
                    n_state = pftw_pkg::ST_POP_TOP;
                end
            end
            pftw_pkg::ST_POP_TOP: begin
                n_cur   = r_heap_q;
                n_count = r_count - TW'(1);
                n_k     = 3'd0;
                if (r_count == TW'(1)) begin
                    n_state = pftw_pkg::ST_NB;
                end else begin
                    hp_ra   = PB'(r_count - TW'(1));
                    n_state = pftw_pkg::ST_POP_LAST;
                end
            end
            pftw_pkg::ST_POP_LAST: begin
                n_item  = r_heap_q;
                n_i     = '0;
                n_state = pftw_pkg::ST_SD;
            end
            pftw_pkg::ST_SD: begin
                if (lc >= (PB+2)'(r_count)) begin
                    hp_we   = 1'b1;
                    hp_wa   = r_i;
                    hp_wd   = r_item;
                    n_state = pftw_pkg::ST_NB;
                end else begin
                    hp_ra   = lc[PB-1:0];
                    n_m     = lc[PB-1:0];
                    n_state = pftw_pkg::ST_SD_L;
                end
            end
            pftw_pkg::ST_SD_L: begin
                n_child = r_heap_q;
                if (lc + (PB+2)'(1) < (PB+2)'(r_count)) begin
                    hp_ra   = PB'(lc + (PB+2)'(1));
                    n_state = pftw_pkg::ST_SD_R;
                end else begin
                    n_state = pftw_pkg::ST_SD_CMP;
                end
            end
            pftw_pkg::ST_SD_R: begin
                if (r_heap_q.lvl < r_child.lvl) begin
                    n_child = r_heap_q;
                    n_m     = PB'(lc + (PB+2)'(1));
                end
                n_state = pftw_pkg::ST_SD_CMP;
            end
            pftw_pkg::ST_SD_CMP: begin
                hp_we = 1'b1;
                hp_wa = r_i;
                if (r_child.lvl < r_item.lvl) begin
                    hp_wd   = r_child;
                    n_i     = r_m;
                    n_state = pftw_pkg::ST_SD;
                end else begin
                    hp_wd   = r_item;
                    n_state = pftw_pkg::ST_NB;
                end
            end
            pftw_pkg::ST_NB: begin
                n_k    = r_k + 3'd1;
                n_nrow = r_cur.row;
                n_ncol = r_cur.col;
                priority case (r_k)
                    3'd0: begin
                        if (RDW'(r_cur.row) + RDW'(1) < r_rows) begin
                            n_nrow  = r_cur.row + RB'(1);
                            n_state = pftw_pkg::ST_NB_ADDR;
                        end
                    end
                    3'd1: begin
                        if (CDW'(r_cur.col) + CDW'(1) < r_cols) begin
                            n_ncol  = r_cur.col + CB'(1);
                            n_state = pftw_pkg::ST_NB_ADDR;
                        end
                    end
                    3'd2: begin
                        if (r_cur.row != '0) begin
                            n_nrow  = r_cur.row - RB'(1);
                            n_state = pftw_pkg::ST_NB_ADDR;
                        end
                    end
                    3'd3: begin
                        if (r_cur.col != '0) begin
                            n_ncol  = r_cur.col - CB'(1);
                            n_state = pftw_pkg::ST_NB_ADDR;
                        end
                    end
                    default: begin
                        n_k     = r_k;
                        n_state = pftw_pkg::ST_POP;
                    end
                endcase
            end
            pftw_pkg::ST_NB_ADDR: begin
                c_ra    = nb_pos;
                n_npos  = nb_pos;
                n_state = pftw_pkg::ST_NB_CHK;
            end
            pftw_pkg::ST_NB_CHK: begin
                if (r_v_q) begin
                    n_state = pftw_pkg::ST_NB;
                end else begin
                    if (r_cur.lvl > r_h_q) begin
                        n_vol = (vsum > SW'(pftw_pkg::VOL_MAX)) ? pftw_pkg::VOL_MAX
                                                                : VB'(vsum);
                    end
                    v_we    = 1'b1;
                    v_wa    = r_npos;
                    v_wd    = 1'b1;
                    n_item  = '{lvl: (r_cur.lvl > r_h_q) ? r_cur.lvl : r_h_q,
                                row: r_nrow, col: r_ncol};
                    n_i     = PB'(r_count);
                    n_count = r_count + TW'(1);
                    n_ret   = pftw_pkg::ST_NB;
                    n_state = pftw_pkg::ST_PU;
                end
            end
            default: begin
                n_state = pftw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pftw_pkg::ST_IDLE;
            r_ret      <= pftw_pkg::ST_IDLE;
            r_cfg_rows <= pftw_pkg::DIM_BITS'(128);
            r_cfg_cols <= pftw_pkg::DIM_BITS'(128);
            r_load     <= '0;
            r_count    <= '0;
            r_vol      <= '0;
            r_valid    <= 1'b0;
            r_sdone    <= 1'b0;
            r_k        <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_load  <= n_load;
            r_count <= n_count;
            r_vol   <= n_vol;
            r_valid <= n_valid;
            r_sdone <= n_sdone;
            r_k     <= n_k;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    pftw_pkg::CFG_ROWS: r_cfg_rows <= i_cfg_data;
                    pftw_pkg::CFG_COLS: r_cfg_cols <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rows  <= n_rows;
        r_cols  <= n_cols;
        r_i     <= n_i;
        r_m     <= n_m;
        r_spos  <= n_spos;
        r_sr    <= n_sr;
        r_sc    <= n_sc;
        r_npos  <= n_npos;
        r_nrow  <= n_nrow;
        r_ncol  <= n_ncol;
        r_item  <= n_item;
        r_child <= n_child;
        r_cur   <= n_cur;
    end

endmodule

// ===== verif/tb_priority_flood_trapped_water.sv =====
`timescale 1ns / 100ps

module tb_priority_flood_trapped_water;

    localparam int MAX_ROWS    = 128;
    localparam int MAX_COLS    = 128;
    localparam int HEIGHT_BITS = 16;
    localparam int CELL_CAP    = MAX_ROWS * MAX_COLS;
    localparam int STALL_LIMIT = 400000;
    localparam int TARGET_WORDS = 1400;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_start = 1'b0;
    logic                             o_busy;
    logic [HEIGHT_BITS-1:0]           i_cell_height = '0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic                             i_cfg_index = pftw_pkg::CFG_ROWS;
    logic [pftw_pkg::DIM_BITS-1:0]    i_cfg_data = '0;
    logic                             o_valid;
    logic [pftw_pkg::VOL_BITS-1:0]    o_water_volume;

    priority_flood_trapped_water #(
        .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .HEIGHT_BITS(HEIGHT_BITS)
    ) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cell_height(i_cell_height), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_water_volume(o_water_volume)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ---------------- predictor state ----------------
    logic [pftw_pkg::DIM_BITS-1:0] rows_reg = 8'd128;
    logic [pftw_pkg::DIM_BITS-1:0] cols_reg = 8'd128;
    logic [HEIGHT_BITS-1:0] heights [CELL_CAP];
    bit                     seen [CELL_CAP];
    int unsigned            hp_lvl [CELL_CAP];
    int unsigned            hp_pos [CELL_CAP];
    int unsigned            hp_cnt;
    int unsigned            loaded = 0;
    longint unsigned        water_acc;

    logic [pftw_pkg::VOL_BITS-1:0] volume_q[$];
    int errors = 0;
    int words_sent = 0;
    int idle_cycles = 0;

    function automatic int unsigned eff_dim(logic [pftw_pkg::DIM_BITS-1:0] v,
                                            int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic void heap_add(int unsigned lvl, int unsigned pos);
        int unsigned i, p, t;
        i = hp_cnt;
        hp_cnt++;
        hp_lvl[i] = lvl;
        hp_pos[i] = pos;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (hp_lvl[p] <= hp_lvl[i]) break;
            t = hp_lvl[p]; hp_lvl[p] = hp_lvl[i]; hp_lvl[i] = t;
            t = hp_pos[p]; hp_pos[p] = hp_pos[i]; hp_pos[i] = t;
            i = p;
        end
    endfunction

    function automatic void heap_take(output int unsigned lvl, output int unsigned pos);
        int unsigned i, l, r, m, t;
        lvl = hp_lvl[0];
        pos = hp_pos[0];
        hp_cnt--;
        hp_lvl[0] = hp_lvl[hp_cnt];
        hp_pos[0] = hp_pos[hp_cnt];
        i = 0;
        forever begin
            l = 2 * i + 1;
            r = l + 1;
            m = i;
            if (l < hp_cnt && hp_lvl[l] < hp_lvl[m]) m = l;
            if (r < hp_cnt && hp_lvl[r] < hp_lvl[m]) m = r;
            if (m == i) break;
            t = hp_lvl[i]; hp_lvl[i] = hp_lvl[m]; hp_lvl[m] = t;
            t = hp_pos[i]; hp_pos[i] = hp_pos[m]; hp_pos[m] = t;
            i = m;
        end
    endfunction

    function automatic void flood_into(int unsigned lvl, int unsigned pos);
        int unsigned h;
        if (seen[pos]) return;
        h = heights[pos];
        if (lvl > h) water_acc += lvl - h;
        seen[pos] = 1'b1;
        heap_add(lvl > h ? lvl : h, pos);
    endfunction

    function automatic logic [pftw_pkg::VOL_BITS-1:0] flood_volume(int unsigned nr,
                                                                   int unsigned nc);
        int unsigned lvl, pos, r, c;
        for (int k = 0; k < CELL_CAP; k++) seen[k] = 1'b0;
        hp_cnt = 0;
        water_acc = 0;
        for (r = 0; r < nr; r++)
            for (c = 0; c < nc; c++)
                if (r == 0 || r == nr - 1 || c == 0 || c == nc - 1) begin
                    seen[r * nc + c] = 1'b1;
                    heap_add(heights[r * nc + c], r * nc + c);
                end
        while (hp_cnt > 0) begin
            heap_take(lvl, pos);
            r = pos / nc;
            c = pos % nc;
            if (r + 1 < nr) flood_into(lvl, pos + nc);
            if (c + 1 < nc) flood_into(lvl, pos + 1);
            if (r > 0) flood_into(lvl, pos - nc);
            if (c > 0) flood_into(lvl, pos - 1);
        end
        return (water_acc > pftw_pkg::VOL_MAX) ? pftw_pkg::VOL_MAX
                                               : water_acc[pftw_pkg::VOL_BITS-1:0];
    endfunction

    // store one cell; returns 1 when it completes a grid
    function automatic bit load_cell(logic [HEIGHT_BITS-1:0] h,
                                     output logic [pftw_pkg::VOL_BITS-1:0] vol);
        int unsigned nr, nc, idx;
        nr = eff_dim(rows_reg, MAX_ROWS);
        nc = eff_dim(cols_reg, MAX_COLS);
        idx = loaded;
        if (idx >= nr * nc) idx = 0;
        heights[idx] = h;
        loaded = idx + 1;
        vol = '0;
        if (loaded < nr * nc) return 1'b0;
        loaded = 0;
        vol = flood_volume(nr, nc);
        return 1'b1;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (volume_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected volume word, expected none, actual %0d",
                         $time, o_water_volume);
            end else begin
                if (o_water_volume !== volume_q[0]) begin
                    errors++;
                    $display("%0t: water_volume mismatch, expected %0d, actual %0d",
                             $time, volume_q[0], o_water_volume);
                end
                void'(volume_q.pop_front());
            end
        end
    end

    // watchdog: cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || (i_cfg_valid && o_cfg_ready) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- drivers ----------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    task automatic send_cell(logic [HEIGHT_BITS-1:0] h, bit use_typed,
                             logic [pftw_pkg::VOL_BITS-1:0] typed);
        logic [pftw_pkg::VOL_BITS-1:0] vol;
        int gap;
        i_cell_height <= h;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        words_sent++;
        if (load_cell(h, vol)) volume_q.push_back(use_typed ? typed : vol);
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (volume_q.size() != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [pftw_pkg::DIM_BITS-1:0] val);
        wait_drained();
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == pftw_pkg::CFG_ROWS) rows_reg = val;
        else cols_reg = val;
    endtask

    // encoded register value for an effective dimension
    function automatic logic [pftw_pkg::DIM_BITS-1:0] dim_code(int unsigned d);
        if (d == 1 && $urandom_range(0, 2) == 0) return '0;
        if (d == 128 && $urandom_range(0, 1) == 0)
            return pftw_pkg::DIM_BITS'($urandom_range(129, 255));
        return pftw_pkg::DIM_BITS'(d);
    endfunction

    function automatic logic [HEIGHT_BITS-1:0] pick_height(int style, bit border);
        case (style)
            0: return HEIGHT_BITS'($urandom_range(0, 65535));
            1: return border ? HEIGHT_BITS'($urandom_range(30000, 65535))
                             : HEIGHT_BITS'($urandom_range(0, 40000));
            2: return HEIGHT_BITS'($urandom_range(0, 15));
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic send_grid(int style);
        int unsigned nr, nc;
        nr = eff_dim(rows_reg, MAX_ROWS);
        nc = eff_dim(cols_reg, MAX_COLS);
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                send_cell(pick_height(style, r == 0 || c == 0 || r == nr - 1 ||
                                      c == nc - 1), 1'b0, '0);
    endtask

    task automatic set_dims(int unsigned nr, int unsigned nc);
        if ($urandom_range(0, 1)) begin
            write_reg(pftw_pkg::CFG_ROWS, dim_code(nr));
            write_reg(pftw_pkg::CFG_COLS, dim_code(nc));
        end else begin
            write_reg(pftw_pkg::CFG_COLS, dim_code(nc));
            write_reg(pftw_pkg::CFG_ROWS, dim_code(nr));
        end
    endtask

    // ---------------- directed table ----------------
    typedef enum logic { ROW_CFG, ROW_CELL } t_row_kind;
    typedef struct {
        t_row_kind                     kind;
        logic                          idx;
        logic [15:0]                   value;
        bit                            typed;
        logic [pftw_pkg::VOL_BITS-1:0] volume;
    } t_stim_row;

    t_stim_row plan [23] = '{
        // zero dimensions act as one: single cell grid
        '{ROW_CFG,  pftw_pkg::CFG_ROWS, 16'd0,     0, 0},
        '{ROW_CFG,  pftw_pkg::CFG_COLS, 16'd0,     0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'hFFFF,  1, 0},
        // 3x3 bowl with a deep center
        '{ROW_CFG,  pftw_pkg::CFG_ROWS, 16'd3,     0, 0},
        '{ROW_CFG,  pftw_pkg::CFG_COLS, 16'd3,     0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'hFFFF,  0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'hFFFF,  0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'hFFFF,  0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'hFFFF,  0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'h0000,  1, 65535},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'hFFFF,  0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'hFFFF,  0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'hFFFF,  0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'hFFFF,  0, 0},
        // partial load, then shrink below load count: restart at index 0
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'd5,     0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'd1,     0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'd9,     0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'd2,     0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'd7,     0, 0},
        '{ROW_CFG,  pftw_pkg::CFG_COLS, 16'd1,     0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'hAAAA,  0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'h0000,  0, 0},
        '{ROW_CELL, pftw_pkg::CFG_ROWS, 16'h5555,  1, 0}
    };

    initial begin
        int unsigned nr, nc;
        int style;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG)
                write_reg(plan[k].idx, plan[k].value[pftw_pkg::DIM_BITS-1:0]);
            else
                send_cell(plan[k].value, plan[k].typed, plan[k].volume);
        end

        // extreme shapes: long strips and a bowl at the largest dimension
        set_dims(128, 1);   send_grid(0);
        set_dims(1, 128);   send_grid(1);
        set_dims(128, 3);   send_grid(1);
        set_dims(3, 128);   send_grid(3);

        while (words_sent < TARGET_WORDS) begin
            if ($urandom_range(0, 19) == 0) begin
                nr = 1;
                nc = $urandom_range(1, 8);
            end else begin
                nr = $urandom_range(1, 9);
                nc = $urandom_range(1, 9);
            end
            if ($urandom_range(0, 1)) set_dims(nr, nc);
            else set_dims(nc, nr);
            repeat ($urandom_range(1, 4)) begin
                style = $urandom_range(0, 9);
                send_grid(style < 5 ? 1 : (style < 7 ? 0 : (style < 9 ? 2 : 3)));
            end
            // extra cells before the next resize, a partial grid unless the grid is small
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 6))
                    send_cell(HEIGHT_BITS'($urandom_range(0, 65535)), 1'b0, '0);
        end

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && volume_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
